@@ rtl/amh_pkg.sv @@
// ----------------------------------------------------------------------------
// amh_pkg: shared constants of the activity max-heap
// Request codes, widths and limits used by the heap unit.
// ----------------------------------------------------------------------------
package amh_pkg;

  localparam int NVARS          = 1024;
  localparam int VAR_W          = $clog2(NVARS);
  localparam int CNT_W          = VAR_W + 1;
  localparam int ACT_W          = 32;
  localparam int ACT_LIMIT_LOG2 = 31;
  localparam int GROW_W         = 18;

  // request kinds
  localparam logic [2:0] REQ_CLEAR   = 3'd0;
  localparam logic [2:0] REQ_APPEND  = 3'd1;
  localparam logic [2:0] REQ_HEAPIFY = 3'd2;
  localparam logic [2:0] REQ_BUMP    = 3'd3;
  localparam logic [2:0] REQ_DECAY   = 3'd4;
  localparam logic [2:0] REQ_ZERO    = 3'd5;

  // configuration register indexes
  localparam logic [0:0] CFG_NUM_VARS = 1'b0;
  localparam logic [0:0] CFG_GROWTH   = 1'b1;

endpackage

@@ rtl/activity_max_heap_unit.sv @@
// ----------------------------------------------------------------------------
// activity_max_heap_unit: VSIDS style max-heap of variables by activity
// Heap slots, slot map and activities live in synchronous RAMs; a sequencer
// reads, compares and writes back one step at a time.
// ----------------------------------------------------------------------------
// Usage:
//  in_  channel: one request item (type, variable). out_ channel: one result
//  item per request (top variable, heap count, empty, error).
//  cfg_ channel: index 0 num_vars, index 1 bump_growth; write while idle.
//  Reject, decay, unknown code and a heapify of fewer than two items go
//  straight to the result; append checks the slot map first; clear/zero
//  sweep all NVARS entries of the slot map or activity RAM; bump adds,
//  may first rescale the activities of all num_vars variables, then climbs
//  level by level; heapify loads each root, moves it down level by level
//  and then stops.
//  One request at a time: the next item is taken the cycle after the result
//  item has been delivered.
//  After reset a sweep marks every variable as not in the heap and zeroes
//  all activities; no item is accepted meanwhile.
//  The result sits in an output register; a stalled receiver holds the unit.
// ----------------------------------------------------------------------------
module activity_max_heap_unit
  import amh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] req_type, [12:3] var_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] top_var, [20:10] heap_count,
                                  // [21] heap_empty, [22] req_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [17:0] {
    S_INIT    = 18'h00001,
    S_IDLE    = 18'h00002,
    S_SWEEP   = 18'h00004,
    S_AP_CHK  = 18'h00008,
    S_BP_ADD  = 18'h00010,
    S_RS      = 18'h00020,
    S_UP      = 18'h00040,
    S_UP_RD   = 18'h00080,
    S_UP_CMP  = 18'h00100,
    S_DN_RD   = 18'h00200,
    S_DN_PV   = 18'h00400,
    S_DN_PA   = 18'h00800,
    S_DN_L    = 18'h01000,
    S_DN_LV   = 18'h02000,
    S_DN_LA   = 18'h04000,
    S_DN_RA   = 18'h08000,
    S_DN_CMP  = 18'h10000,
    S_DONE    = 18'h20000
  } state_t;

  // memories
  logic [ACT_W-1:0] act_mem  [NVARS];
  logic [VAR_W-1:0] heap_mem [NVARS];
  logic [CNT_W-1:0] slot_mem [NVARS];

  logic             act_we, heap_we, slot_we;
  logic [VAR_W-1:0] act_wa, act_ra, heap_wa, heap_ra, slot_wa, slot_ra;
  logic [ACT_W-1:0] act_wd, act_rd;
  logic [VAR_W-1:0] heap_wd, heap_rd;
  logic [CNT_W-1:0] slot_wd, slot_rd;

  always_ff @(posedge clk) begin
    if (act_we) act_mem[act_wa] <= act_wd;
    act_rd <= act_mem[act_ra];
  end
  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_rd <= heap_mem[heap_ra];
  end
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end

  state_t            st_r, st_nxt;
  logic [CNT_W-1:0]  nv_r, nv_nxt;
  logic [GROW_W-1:0] grow_r, grow_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [ACT_W-1:0]  bump_r, bump_nxt;
  logic [VAR_W-1:0]  top_r, top_nxt;
  logic [VAR_W-1:0]  var_r, var_nxt;
  logic              err_r, err_nxt;
  logic              oval_r, oval_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;     // sweep index / heapify root
  logic [CNT_W-1:0]  pos_r, pos_nxt;     // current heap position (hole)
  logic [VAR_W-1:0]  pv_r, pv_nxt;       // variable being moved
  logic [ACT_W-1:0]  pa_r, pa_nxt;       // its activity
  logic [VAR_W-1:0]  cv_r, cv_nxt;       // chosen child / parent variable
  logic [ACT_W-1:0]  ca_r, ca_nxt;       // its activity
  logic [CNT_W-1:0]  cpos_r, cpos_nxt;   // chosen child position
  logic [VAR_W-1:0]  rv_r, rv_nxt;       // right child variable
  logic              rsw_r, rsw_nxt;     // rescale sweep: read phase done
  logic              sw_act_r, sw_act_nxt; // sweep zeroes activities
  logic              sw_slot_r, sw_slot_nxt; // sweep empties the slot map

  logic [CNT_W-1:0] nv_use;
  assign nv_use = (nv_r > CNT_W'(NVARS)) ? CNT_W'(NVARS) : nv_r;

  logic [ACT_W:0]          sum;
  logic [ACT_W-1:0]        sat_sum;
  logic [ACT_W+GROW_W-1:0] prod;
  logic [CNT_W:0]          lidx, ridx;
  logic [CNT_W-1:0]        par;
  logic [VAR_W-1:0]        top_out;
  assign sum     = {1'b0, act_rd} + {1'b0, bump_r};
  assign sat_sum = sum[ACT_W] ? '1 : sum[ACT_W-1:0];
  assign prod    = bump_r * grow_r;
  assign lidx    = {pos_r, 1'b1};
  assign ridx    = lidx + 1'b1;
  assign par     = (pos_r - 1'b1) >> 1;
  assign top_out = (fill_r == '0) ? '0 : top_r;

  assign in_tready  = (st_r == S_IDLE) && !oval_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = oval_r;
  assign out_tdata  = {1'b0, err_r, (fill_r == '0), fill_r, top_out};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; nv_r <= '0; grow_r <= GROW_W'(68985);
      fill_r <= '0; bump_r <= ACT_W'(65536); oval_r <= 1'b0;
      cnt_r <= '0; sw_act_r <= 1'b1; sw_slot_r <= 1'b1; rsw_r <= 1'b0;
      top_r <= '0; err_r <= 1'b0;
    end else begin
      st_r <= st_nxt; nv_r <= nv_nxt; grow_r <= grow_nxt; fill_r <= fill_nxt;
      bump_r <= bump_nxt; oval_r <= oval_nxt; cnt_r <= cnt_nxt;
      sw_act_r <= sw_act_nxt; sw_slot_r <= sw_slot_nxt; rsw_r <= rsw_nxt;
      top_r <= top_nxt; err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    var_r <= var_nxt; pos_r <= pos_nxt; pv_r <= pv_nxt; pa_r <= pa_nxt;
    cv_r <= cv_nxt; ca_r <= ca_nxt; cpos_r <= cpos_nxt; rv_r <= rv_nxt;
  end

  always_comb begin
    st_nxt = st_r; nv_nxt = nv_r; grow_nxt = grow_r; fill_nxt = fill_r;
    bump_nxt = bump_r; top_nxt = top_r; var_nxt = var_r;
    err_nxt = err_r; oval_nxt = oval_r; cnt_nxt = cnt_r; pos_nxt = pos_r;
    pv_nxt = pv_r; pa_nxt = pa_r; cv_nxt = cv_r; ca_nxt = ca_r;
    cpos_nxt = cpos_r; rv_nxt = rv_r; rsw_nxt = rsw_r;
    sw_act_nxt = sw_act_r; sw_slot_nxt = sw_slot_r;
    act_we = 1'b0; act_wa = '0; act_wd = '0; act_ra = '0;
    heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0;
    slot_we = 1'b0; slot_wa = '0; slot_wd = '0; slot_ra = '0;

    if (cfg_valid) begin
      if (cfg_index == CFG_NUM_VARS) nv_nxt = cfg_data[CNT_W-1:0];
      else grow_nxt = cfg_data[GROW_W-1:0];
    end
    if (oval_r && out_tready) oval_nxt = 1'b0;

    unique case (st_r)
      // reset sweep and clear/zero sweeps
      S_INIT, S_SWEEP: begin
        act_we = sw_act_r; act_wa = cnt_r[VAR_W-1:0];
        slot_we = sw_slot_r; slot_wa = cnt_r[VAR_W-1:0]; slot_wd = '1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NVARS - 1)) begin
          cnt_nxt = '0;
          st_nxt = (st_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          var_nxt = in_tdata[12:3]; err_nxt = 1'b0;
          slot_ra = in_tdata[12:3]; act_ra = in_tdata[12:3];
          unique case (in_tdata[2:0])
            REQ_CLEAR: begin
              sw_act_nxt = 1'b0; sw_slot_nxt = 1'b1; fill_nxt = '0;
              cnt_nxt = '0; st_nxt = S_SWEEP;
            end
            REQ_ZERO: begin
              sw_act_nxt = 1'b1; sw_slot_nxt = 1'b0;
              cnt_nxt = '0; st_nxt = S_SWEEP;
            end
            REQ_APPEND: begin
              if ({1'b0, in_tdata[12:3]} >= nv_use || fill_r >= CNT_W'(NVARS)) begin
                err_nxt = 1'b1; st_nxt = S_DONE;
              end else st_nxt = S_AP_CHK;
            end
            REQ_BUMP: begin
              if ({1'b0, in_tdata[12:3]} >= nv_use) begin
                err_nxt = 1'b1; st_nxt = S_DONE;
              end else st_nxt = S_BP_ADD;
            end
            REQ_DECAY: begin
              bump_nxt = (|prod[ACT_W+GROW_W-1:ACT_W+16]) ? '1
                         : prod[ACT_W+15:16];
              st_nxt = S_DONE;
            end
            REQ_HEAPIFY: begin
              // roots from fill/2-1 down to 0
              if ((fill_r >> 1) == '0) st_nxt = S_DONE;
              else begin
                cnt_nxt = (fill_r >> 1) - 1'b1;
                pos_nxt = (fill_r >> 1) - 1'b1;
                st_nxt = S_DN_RD;
              end
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      // append only if the variable is not in the heap yet
      S_AP_CHK: begin
        if (slot_rd[CNT_W-1]) begin
          heap_we = 1'b1; heap_wa = fill_r[VAR_W-1:0]; heap_wd = var_r;
          slot_we = 1'b1; slot_wa = var_r; slot_wd = fill_r;
          fill_nxt = fill_r + 1'b1;
        end
        st_nxt = S_DONE;
      end
      // bump: saturating add, rescale check
      S_BP_ADD: begin
        act_we = 1'b1; act_wa = var_r; act_wd = sat_sum;
        pa_nxt = sat_sum; pv_nxt = var_r;
        pos_nxt = slot_rd;
        if ({1'b0, sat_sum} > (33'd1 << ACT_LIMIT_LOG2)) begin
          bump_nxt = bump_r >> 16; cnt_nxt = '0; rsw_nxt = 1'b0;
          pa_nxt = sat_sum >> 16;
          st_nxt = S_RS;
        end else st_nxt = S_UP;
      end
      // rescale: read one entry, then write it shifted
      S_RS: begin
        if (cnt_r >= nv_use) st_nxt = S_UP;
        else if (!rsw_r) begin
          act_ra = cnt_r[VAR_W-1:0]; rsw_nxt = 1'b1;
        end else begin
          act_we = 1'b1; act_wa = cnt_r[VAR_W-1:0]; act_wd = act_rd >> 16;
          cnt_nxt = cnt_r + 1'b1; rsw_nxt = 1'b0;
        end
      end
      // sift up: pos_r holds the hole, pv_r/pa_r the moving variable
      S_UP: begin
        if (pos_r[CNT_W-1]) st_nxt = S_DONE;
        else if (pos_r == '0) begin
          heap_we = 1'b1; heap_wa = '0; heap_wd = pv_r;
          slot_we = 1'b1; slot_wa = pv_r; slot_wd = pos_r;
          st_nxt = S_DONE;
        end else begin
          heap_ra = par[VAR_W-1:0]; st_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        act_ra = heap_rd; cv_nxt = heap_rd; st_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (act_rd >= pa_r) begin
          heap_we = 1'b1; heap_wa = pos_r[VAR_W-1:0]; heap_wd = pv_r;
          slot_we = 1'b1; slot_wa = pv_r; slot_wd = pos_r;
          st_nxt = S_DONE;
        end else begin
          heap_we = 1'b1; heap_wa = pos_r[VAR_W-1:0]; heap_wd = cv_r;
          slot_we = 1'b1; slot_wa = cv_r; slot_wd = pos_r;
          pos_nxt = par;
          st_nxt = S_UP;
        end
      end
      // sift down from pos_r: load the root variable and its activity
      S_DN_RD: begin
        heap_ra = pos_r[VAR_W-1:0]; st_nxt = S_DN_PV;
      end
      S_DN_PV: begin
        pv_nxt = heap_rd; act_ra = heap_rd; st_nxt = S_DN_PA;
      end
      S_DN_PA: begin
        pa_nxt = act_rd; st_nxt = S_DN_L;
      end
      S_DN_L: begin
        if (lidx >= {1'b0, fill_r}) begin
          heap_we = 1'b1; heap_wa = pos_r[VAR_W-1:0]; heap_wd = pv_r;
          slot_we = 1'b1; slot_wa = pv_r; slot_wd = pos_r;
          if (cnt_r == '0) st_nxt = S_DONE;
          else begin
            cnt_nxt = cnt_r - 1'b1; pos_nxt = cnt_r - 1'b1;
            st_nxt = S_DN_RD;
          end
        end else begin
          heap_ra = lidx[VAR_W-1:0]; st_nxt = S_DN_LV;
        end
      end
      S_DN_LV: begin
        cv_nxt = heap_rd; cpos_nxt = lidx[CNT_W-1:0]; act_ra = heap_rd;
        if (ridx < {1'b0, fill_r}) heap_ra = ridx[VAR_W-1:0];
        st_nxt = S_DN_LA;
      end
      S_DN_LA: begin
        ca_nxt = act_rd;
        if (ridx < {1'b0, fill_r}) begin
          rv_nxt = heap_rd; act_ra = heap_rd; st_nxt = S_DN_RA;
        end else st_nxt = S_DN_CMP;
      end
      // left child wins a tie
      S_DN_RA: begin
        if (ca_r < act_rd) begin
          ca_nxt = act_rd; cv_nxt = rv_r; cpos_nxt = ridx[CNT_W-1:0];
        end
        st_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (ca_r <= pa_r) begin
          heap_we = 1'b1; heap_wa = pos_r[VAR_W-1:0]; heap_wd = pv_r;
          slot_we = 1'b1; slot_wa = pv_r; slot_wd = pos_r;
          if (cnt_r == '0) st_nxt = S_DONE;
          else begin
            cnt_nxt = cnt_r - 1'b1; pos_nxt = cnt_r - 1'b1;
            st_nxt = S_DN_RD;
          end
        end else begin
          // child moves up into the hole
          heap_we = 1'b1; heap_wa = pos_r[VAR_W-1:0]; heap_wd = cv_r;
          slot_we = 1'b1; slot_wa = cv_r; slot_wd = pos_r;
          pos_nxt = cpos_r;
          st_nxt = S_DN_L;
        end
      end
      S_DONE: begin
        oval_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    // top of heap follows the root slot writes
    if (heap_we && heap_wa == '0) top_nxt = heap_wd;
  end

endmodule
